### design/three_region_radiance_down_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-region downward radiance block
// Short forms of concurrent assertions clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef THREE_REGION_RADIANCE_DOWN_ASSERT_SVH
`define THREE_REGION_RADIANCE_DOWN_ASSERT_SVH

// same-cycle implication
`define TRRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TRRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/trrd_pkg.sv
// ----------------------------------------------------------------------------
// trrd_pkg
// Types, constants and the rounding/saturation helper shared by the
// three-region downward radiance block.
// ----------------------------------------------------------------------------
package trrd_pkg;

	localparam int NUM_POINTS_DEF = 256;
	localparam int NUM_REGIONS    = 3;
	localparam int IDX_W          = 8;
	localparam int COEF_W         = 17;
	localparam int RAD_W          = 32;
	localparam int FRAC_W         = 16;
	localparam int PROD_W         = COEF_W + RAD_W;
	localparam int ACC_W          = PROD_W + 2;
	localparam int SUM_W          = ACC_W + 2;
	localparam int ROW_W          = $clog2(NUM_REGIONS);

	localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

	// request kinds
	localparam logic KIND_OVERLAP = 1'b0;
	localparam logic KIND_LAYER   = 1'b1;

	typedef logic [NUM_REGIONS-1:0][COEF_W-1:0] coef_vec_t;
	typedef logic [NUM_REGIONS-1:0][RAD_W-1:0]  rad_vec_t;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  index;
		logic              first_layer;
		logic              last_layer;
		logic              layer_clear;
		logic              next_clear;
		logic [COEF_W-1:0] coef_clear;
		logic [COEF_W-1:0] coef_cloud1;
		logic [COEF_W-1:0] coef_cloud2;
		logic [RAD_W-1:0]  src_clear;
		logic [RAD_W-1:0]  src_cloud1;
		logic [RAD_W-1:0]  src_cloud2;
	} sample_t;

	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		logic [RAD_W-1:0] rad_clear;
		logic [RAD_W-1:0] rad_cloud1;
		logic [RAD_W-1:0] rad_cloud2;
	} result_t;

	// control flags that travel with a request down the pipeline
	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] index;
		logic             first_layer;
		logic             last_layer;
		logic             layer_clear;
		logic             next_clear;
	} stage_ctl_t;

	// per-lane control from the top level
	typedef struct packed {
		logic adv;
		logic rd_en;
		logic zero_top;
		logic zero_base;
	} lane_ctrl_t;

	// overlap stage control from the top level
	typedef struct packed {
		logic             adv;
		logic             ovl_we;
		logic [ROW_W-1:0] ovl_row;
		logic             rows_one;
		logic             copy;
	} merge_ctrl_t;

	// (acc + 0.5 ulp) >> 16 plus add, saturated to 32 bits
	function automatic logic [RAD_W-1:0] sat_round(input logic [ACC_W-1:0] acc,
			input logic [RAD_W-1:0] add);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(acc) + SUM_W'(ROUND_HALF) + SUM_W'({add, {FRAC_W{1'b0}}});
		return (sum[SUM_W-1:FRAC_W+RAD_W] != '0) ? {RAD_W{1'b1}}
			: sum[FRAC_W+RAD_W-1:FRAC_W];
	endfunction

endpackage

### design/trrd_ram.sv
// ----------------------------------------------------------------------------
// trrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trrd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/trrd_lane.sv
// ----------------------------------------------------------------------------
// trrd_lane
// One region lane: stores the region's top radiance per spectral point and
// computes base = T * top + S over two pipeline stages.
// ----------------------------------------------------------------------------
module trrd_lane #(
	parameter int NUM_POINTS = trrd_pkg::NUM_POINTS_DEF,
	localparam int ADDR_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1
) (
	input  logic                          clk,
	input  trrd_pkg::lane_ctrl_t          ctrl,
	input  logic [ADDR_W-1:0]             rd_addr,
	input  logic                          wr_en,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic [trrd_pkg::RAD_W-1:0]    wr_data,
	input  logic [trrd_pkg::COEF_W-1:0]   coef_s1,
	input  logic [trrd_pkg::RAD_W-1:0]    src_s1,
	output logic [trrd_pkg::RAD_W-1:0]    base_s3
);

	import trrd_pkg::*;

	logic [RAD_W-1:0]  rd_data;
	logic [RAD_W-1:0]  top_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [RAD_W-1:0]  src_s2;

	trrd_ram #(
		.WIDTH (RAD_W),
		.DEPTH (NUM_POINTS)
	) u_top_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (ctrl.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// treat top as zero on the first layer or an out-of-range point
	assign top_s1 = ctrl.zero_top ? '0 : rd_data;

	// multiply, then round, add source and saturate
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			prod_s2 <= PROD_W'(coef_s1) * PROD_W'(top_s1);
			src_s2  <= src_s1;
			base_s3 <= ctrl.zero_base ? '0 : sat_round(ACC_W'(prod_s2), src_s2);
		end
	end

endmodule

### design/trrd_merge.sv
// ----------------------------------------------------------------------------
// trrd_merge
// Merging stage: holds the 3x3 overlap matrix and maps the lanes' base
// radiances into the next layer's top radiances.
// ----------------------------------------------------------------------------
module trrd_merge (
	input  logic                  clk,
	input  trrd_pkg::merge_ctrl_t ctrl,
	input  trrd_pkg::coef_vec_t   ovl_coef,
	input  trrd_pkg::rad_vec_t    base_s3,
	output trrd_pkg::rad_vec_t    new_top
);

	import trrd_pkg::*;

	logic [COEF_W-1:0] ovl_q   [NUM_REGIONS][NUM_REGIONS];
	logic [PROD_W-1:0] prod_s4 [NUM_REGIONS][NUM_REGIONS];
	logic              copy_s4;
	logic [RAD_W-1:0]  base0_s4;

	// load overlap rows in request order; form all row-by-column products
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int r = 0; r < NUM_REGIONS; r++) begin
				if (ctrl.ovl_we && ctrl.ovl_row == ROW_W'(r)) begin
					for (int j = 0; j < NUM_REGIONS; j++) begin
						ovl_q[r][j] <= ovl_coef[j];
					end
				end
			end
			for (int r = 0; r < NUM_REGIONS; r++) begin
				for (int j = 0; j < NUM_REGIONS; j++) begin
					prod_s4[r][j] <= (r != 0 && ctrl.rows_one) ? '0
						: PROD_W'(ovl_q[r][j]) * PROD_W'(base_s3[r]);
				end
			end
			copy_s4  <= ctrl.copy;
			base0_s4 <= base_s3[0];
		end
	end

	// sum each column, round and saturate; copy the clear base when asked
	always_comb begin
		logic [ACC_W-1:0] acc;
		for (int j = 0; j < NUM_REGIONS; j++) begin
			acc = '0;
			for (int r = 0; r < NUM_REGIONS; r++) begin
				acc = acc + ACC_W'(prod_s4[r][j]);
			end
			new_top[j] = (j == 0 && copy_s4) ? base0_s4 : sat_round(acc, '0);
		end
	end

endmodule

### design/three_region_radiance_down.sv
// ----------------------------------------------------------------------------
// three_region_radiance_down
// Downward longwave radiance through layers split into one clear and two
// cloudy regions, one spectral point per request, three lanes plus merge.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid/sample_ready/sample) carries overlap row
//   loads (kind 0) and layer samples (kind 1). result channel
//   (result_valid/result_ready/result) returns the surface radiances of
//   every last-layer sample, in request order.
//   A result passes through stages 1 to 3 and then the result register.
//   Throughput: one request per cycle while the skid register is empty. A layer sample is held off while an
//   earlier sample for the same spectral point is still within the four
//   stages ahead of its top-radiance write.
//   Reset: after arst_n is released the top-radiance memories are swept to
//   zero, one point per cycle; sample_ready stays low until the sweep ends.
//   Stall: a result register and a skid register absorb two results; the
//   pipeline freezes only when both are full.
// ----------------------------------------------------------------------------
module three_region_radiance_down #(
	parameter int NUM_POINTS = trrd_pkg::NUM_POINTS_DEF,
	localparam int ADDR_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  trrd_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_ready,
	output trrd_pkg::result_t result
);

	import trrd_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	stage_ctl_t  ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	coef_vec_t   coef_s1, coef_s2, coef_s3;
	rad_vec_t    src_s1;
	rad_vec_t    base_s3;
	rad_vec_t    new_top;

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;

	logic       adv, accept, hazard, push, we_s4, copy_s4;
	result_t    push_item;
	lane_ctrl_t lane_ctrl [NUM_REGIONS];
	logic       lane_we   [NUM_REGIONS];
	logic [ADDR_W-1:0] lane_waddr;
	merge_ctrl_t merge_ctrl;

	function automatic logic point_ok(input logic [IDX_W-1:0] idx);
		return 32'(idx) < 32'(NUM_POINTS);
	endfunction

	function automatic logic writes_top(input stage_ctl_t c);
		return c.kind == KIND_LAYER && !c.last_layer && point_ok(c.index);
	endfunction

	// hold off a request whose point is still being updated downstream
	assign hazard = (v_s1 && writes_top(ctl_s1) && ctl_s1.index == sample.index)
		|| (v_s2 && writes_top(ctl_s2) && ctl_s2.index == sample.index)
		|| (v_s3 && writes_top(ctl_s3) && ctl_s3.index == sample.index)
		|| (v_s4 && writes_top(ctl_s4) && ctl_s4.index == sample.index);

	assign adv          = !skid_valid_q;
	assign sample_ready = adv && !clr_busy_q && !hazard;
	assign accept       = sample_valid && sample_ready;

	// control state: stage valids, clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (adv) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
			if (clr_busy_q) begin
				if (clr_addr_q == ADDR_W'(NUM_POINTS - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
				end
			end
		end
	end

	// advance request payload down the pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1  <= '{kind: sample.kind, index: sample.index,
				first_layer: sample.first_layer, last_layer: sample.last_layer,
				layer_clear: sample.layer_clear, next_clear: sample.next_clear};
			coef_s1 <= {sample.coef_cloud2, sample.coef_cloud1, sample.coef_clear};
			src_s1  <= {sample.src_cloud2, sample.src_cloud1, sample.src_clear};
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			ctl_s4  <= ctl_s3;
			coef_s2 <= coef_s1;
			coef_s3 <= coef_s2;
		end
	end

	// top-radiance write-back, or zero fill during the sweep
	assign copy_s4    = ctl_s4.layer_clear && ctl_s4.next_clear;
	assign we_s4      = adv && v_s4 && writes_top(ctl_s4);
	assign lane_waddr = clr_busy_q ? clr_addr_q : ADDR_W'(ctl_s4.index);

	always_comb begin
		for (int l = 0; l < NUM_REGIONS; l++) begin
			lane_ctrl[l] = '{adv: adv, rd_en: accept,
				zero_top: ctl_s1.first_layer || !point_ok(ctl_s1.index),
				zero_base: (l != 0) && ctl_s2.layer_clear};
			lane_we[l] = clr_busy_q || (we_s4 && (l == 0 || !copy_s4));
		end
	end

	for (genvar l = 0; l < NUM_REGIONS; l++) begin : g_lane
		trrd_lane #(
			.NUM_POINTS (NUM_POINTS)
		) u_lane (
			.clk     (clk),
			.ctrl    (lane_ctrl[l]),
			.rd_addr (ADDR_W'(sample.index)),
			.wr_en   (lane_we[l]),
			.wr_addr (lane_waddr),
			.wr_data (clr_busy_q ? '0 : new_top[l]),
			.coef_s1 (coef_s1[l]),
			.src_s1  (src_s1[l]),
			.base_s3 (base_s3[l])
		);
	end

	// overlap row loads and mapping controls at stage 3
	assign merge_ctrl = '{adv: adv,
		ovl_we: v_s3 && ctl_s3.kind == KIND_OVERLAP && 32'(ctl_s3.index) < NUM_REGIONS,
		ovl_row: ROW_W'(ctl_s3.index),
		rows_one: ctl_s3.layer_clear,
		copy: ctl_s3.layer_clear && ctl_s3.next_clear};

	trrd_merge u_merge (
		.clk      (clk),
		.ctrl     (merge_ctrl),
		.ovl_coef (coef_s3),
		.base_s3  (base_s3),
		.new_top  (new_top)
	);

	// emit surface radiances of a last-layer sample
	assign push      = adv && v_s3 && ctl_s3.kind == KIND_LAYER && ctl_s3.last_layer;
	assign push_item = '{point_index: ctl_s3.index, rad_clear: base_s3[0],
		rad_cloud1: base_s3[1], rad_cloud2: base_s3[2]};

	// result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result_ready) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= push_item;
			end else begin
				out_q <= push_item;
			end
		end else if (push) begin
			skid_q <= push_item;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### design/trrd_checker.sv
// ----------------------------------------------------------------------------
// trrd_checker
// Port-level checks for the three-region downward radiance block, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "three_region_radiance_down_assert.svh"

module trrd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input trrd_pkg::sample_t sample,
	input logic              result_valid,
	input logic              result_ready,
	input trrd_pkg::result_t result
);

	import trrd_pkg::*;

	localparam int                  PEND_W      = 3;
	localparam logic [PEND_W-1:0]   MAX_PENDING = 3'd5;

	logic [PEND_W-1:0] pending_q;
	logic              take_last, deliver;

	assign take_last = sample_valid && sample_ready && sample.kind == KIND_LAYER
		&& sample.last_layer;
	assign deliver   = result_valid && result_ready;

	// count results owed to the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + PEND_W'(take_last) - PEND_W'(deliver);
		end
	end

	`TRRD_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")
	`TRRD_ASSERT_IMP(a_no_spurious, clk, arst_n, result_valid, pending_q != '0, "result without a last-layer request")
	`TRRD_ASSERT_IMP(a_pending_bound, clk, arst_n, 1'b1, pending_q <= MAX_PENDING, "too many results in flight")
	`TRRD_ASSERT_IMP(a_full_stall, clk, arst_n, pending_q == MAX_PENDING, !sample_ready, "request taken with all stages full")

endmodule

bind three_region_radiance_down trrd_checker u_trrd_checker (.*);

### dv/tb_three_region_radiance_down.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_region_radiance_down
// Self-checking bench for the three-region downward radiance block. Requests
// go in one at a time through a paced driver. A bit-accurate predictor keeps
// its own top radiances and overlap matrix, and queues the surface radiances
// that each last-layer sample should return. A monitor compares every result
// that is taken against the oldest queued one. Directed tests cover row loads,
// clear/cloudy columns and field extremes. A back-pressure test stalls the
// result side for a long stretch. A random test sends interleaved layer
// columns mixed with noise and broken sequences.
// ----------------------------------------------------------------------------
module tb_three_region_radiance_down;
	import trrd_pkg::*;

	localparam int PTS          = 256;
	localparam int DRAIN_CYCLES = 12;
	localparam int SHOW_MAX     = 10;
	localparam int RANDOM_ITEMS = 430;

	logic    clk;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_ready;
	sample_t sample;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	// predictor state
	logic [RAD_W-1:0]  top_rad [NUM_REGIONS][PTS];
	logic [COEF_W-1:0] overlap [NUM_REGIONS][NUM_REGIONS];
	result_t           surface_q[$];

	int mismatches;
	int hold_req;
	bit res_taken;
	bit feed_pace;
	bit sink_pace;

	three_region_radiance_down #(.NUM_POINTS(PTS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// round the Q.16 accumulator, add the source, clamp to 32 bits
	function automatic logic [RAD_W-1:0] round_clamp(input logic [63:0] acc,
			input logic [RAD_W-1:0] add);
		logic [63:0] v;
		v = ((acc + 64'h8000) >> 16) + 64'(add);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[RAD_W-1:0];
	endfunction

	// advance the radiance state by one request; queue the surface result
	function automatic void radiance_step(input sample_t s);
		logic [RAD_W-1:0]  top  [NUM_REGIONS];
		logic [RAD_W-1:0]  base [NUM_REGIONS];
		logic [COEF_W-1:0] trans[NUM_REGIONS];
		logic [RAD_W-1:0]  src  [NUM_REGIONS];
		logic [63:0]       acc;
		bit                in_range;
		int                rows;
		result_t           r;
		trans[0] = s.coef_clear;
		trans[1] = s.coef_cloud1;
		trans[2] = s.coef_cloud2;
		src[0]   = s.src_clear;
		src[1]   = s.src_cloud1;
		src[2]   = s.src_cloud2;
		if (s.kind == KIND_OVERLAP) begin
			if (s.index < NUM_REGIONS)
				for (int j = 0; j < NUM_REGIONS; j++)
					overlap[s.index][j] = trans[j];
			return;
		end
		in_range = s.index < PTS;
		for (int k = 0; k < NUM_REGIONS; k++)
			top[k] = (in_range && !s.first_layer) ? top_rad[k][s.index] : '0;
		base[0] = round_clamp(64'(trans[0]) * 64'(top[0]), src[0]);
		base[1] = '0;
		base[2] = '0;
		if (!s.layer_clear)
			for (int k = 1; k < NUM_REGIONS; k++)
				base[k] = round_clamp(64'(trans[k]) * 64'(top[k]), src[k]);
		if (s.last_layer) begin
			r.point_index = s.index;
			r.rad_clear   = base[0];
			r.rad_cloud1  = base[1];
			r.rad_cloud2  = base[2];
			surface_q.push_back(r);
			return;
		end
		if (!in_range)
			return;
		if (s.layer_clear && s.next_clear) begin
			top_rad[0][s.index] = base[0];
		end else begin
			rows = s.layer_clear ? 1 : NUM_REGIONS;
			for (int j = 0; j < NUM_REGIONS; j++) begin
				acc = '0;
				for (int k = 0; k < rows; k++)
					acc += 64'(overlap[k][j]) * 64'(base[k]);
				top_rad[j][s.index] = round_clamp(acc, '0);
			end
		end
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 17'd65536;
			2:       return COEF_W'($urandom_range(0, 17'h1FFFF));
			default: return COEF_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [RAD_W-1:0] rand_src();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 32'hFFFF_FFFF;
			2, 3:    return $urandom;
			default: return $urandom_range(0, 32'h00FF_FFFF);
		endcase
	endfunction

	function automatic sample_t make_layer(input logic [IDX_W-1:0] pt, input bit first,
			input bit last, input bit lclr, input bit nclr);
		sample_t s;
		s.kind        = KIND_LAYER;
		s.index       = pt;
		s.first_layer = first;
		s.last_layer  = last;
		s.layer_clear = lclr;
		s.next_clear  = nclr;
		s.coef_clear  = rand_coef();
		s.coef_cloud1 = rand_coef();
		s.coef_cloud2 = rand_coef();
		s.src_clear   = rand_src();
		s.src_cloud1  = rand_src();
		s.src_cloud2  = rand_src();
		return s;
	endfunction

	function automatic sample_t make_row(input logic [IDX_W-1:0] row,
			input logic [COEF_W-1:0] c0, input logic [COEF_W-1:0] c1,
			input logic [COEF_W-1:0] c2);
		sample_t s;
		s             = make_layer(row, bit'($urandom_range(0, 1)),
			bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
			bit'($urandom_range(0, 1)));
		s.kind        = KIND_OVERLAP;
		s.coef_clear  = c0;
		s.coef_cloud1 = c1;
		s.coef_cloud2 = c2;
		return s;
	endfunction

	// offer one request and hold it until taken; called at a falling edge
	task automatic send_request(input sample_t s);
		int gap;
		gap = feed_pace ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		radiance_step(s);
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	// drop valid and wait for every queued result plus the pipeline depth
	task automatic wait_drain();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (surface_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input result_t exp, input result_t act);
		mismatches++;
		if (mismatches <= SHOW_MAX)
			$display("%0t %s: exp pt=%0d %h %h %h, got pt=%0d %h %h %h", $time, what,
				exp.point_index, exp.rad_clear, exp.rad_cloud1, exp.rad_cloud2,
				act.point_index, act.rad_clear, act.rad_cloud1, act.rad_cloud2);
	endtask

	// compare each taken result with the oldest expected one
	always @(posedge clk) begin
		result_t exp;
		if (arst_n && result_valid && result_ready) begin
			res_taken = 1'b1;
			if (surface_q.size() == 0) begin
				report_mismatch("unexpected result", '0, result);
			end else begin
				exp = surface_q.pop_front();
				if (result.point_index !== exp.point_index
						|| result.rad_clear !== exp.rad_clear
						|| result.rad_cloud1 !== exp.rad_cloud1
						|| result.rad_cloud2 !== exp.rad_cloud2)
					report_mismatch("result mismatch", exp, result);
			end
		end
	end

	// result side: random stalls per result, plus long hold-offs on request
	initial begin : result_sink
		int gap_left;
		int hold_left;
		gap_left     = 0;
		hold_left    = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (res_taken) begin
				res_taken = 1'b0;
				gap_left  = sink_pace ? $urandom_range(0, 10) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// load all three rows; rows above 2 must be ignored
	task automatic test_overlap_rows();
		sample_t s;
		send_request(make_row(0, 17'd40000, 17'd15000, 17'd10536));
		s = make_row(1, 17'd0, 17'd65536, 17'd0);
		s.last_layer = 1'b1;
		send_request(s);
		send_request(make_row(2, 17'd20000, 17'd0, 17'd45536));
		send_request(make_row(3, '1, '1, '1));
		send_request(make_row(8'hFF, '1, '1, '1));
		wait_drain();
	endtask

	// clear copy, clear spread through row 0, cloudy last layer
	task automatic test_clear_column();
		sample_t s;
		s = make_layer(5, 1, 0, 1, 1);
		s.coef_clear = 17'd65536;
		s.src_clear  = 32'h0001_8000;
		send_request(s);
		s = make_layer(5, 0, 0, 1, 0);
		s.coef_clear = 17'd32768;
		send_request(s);
		send_request(make_layer(5, 0, 1, 0, 0));
		wait_drain();
	endtask

	// cloudy layers ignore next_clear; a clear last layer zeroes the clouds
	task automatic test_cloudy_column();
		send_request(make_layer(6, 1, 0, 0, 0));
		send_request(make_layer(6, 0, 0, 0, 1));
		send_request(make_layer(6, 0, 1, 1, 0));
		wait_drain();
	endtask

	// saturation, zero fields, unwritten points, first layer over stored tops
	task automatic test_field_extremes();
		sample_t s;
		s = make_layer(0, 1, 1, 0, 0);
		s.src_clear  = '1;
		s.src_cloud1 = '1;
		s.src_cloud2 = '1;
		send_request(s);
		for (int n = 0; n < 2; n++) begin
			s = make_layer(8'hFF, n == 0, n == 1, 0, 0);
			s.coef_clear  = '1;
			s.coef_cloud1 = '1;
			s.coef_cloud2 = '1;
			s.src_clear   = '1;
			s.src_cloud1  = '1;
			s.src_cloud2  = '1;
			send_request(s);
		end
		send_request(make_layer(200, 0, 1, 1, 1));
		send_request(make_layer(0, 0, 1, 0, 0));
		s = make_layer(7, 1, 0, 0, 0);
		s.coef_clear  = '0;
		s.coef_cloud1 = '0;
		s.coef_cloud2 = '0;
		s.src_clear   = '0;
		s.src_cloud1  = '0;
		s.src_cloud2  = '0;
		send_request(s);
		s = make_layer(7, 0, 1, 0, 0);
		s.coef_clear  = 17'd65536;
		s.coef_cloud1 = 17'd65536;
		s.coef_cloud2 = 17'd65536;
		s.src_clear   = '0;
		s.src_cloud1  = '0;
		s.src_cloud2  = '0;
		send_request(s);
		send_request(make_layer(5, 1, 1, 0, 0));
		wait_drain();
	endtask

	// hold the result side off while requests keep coming back to back
	task automatic test_result_backpressure();
		feed_pace = 1'b0;
		sink_pace = 1'b0;
		hold_req  = 120;
		for (int n = 0; n < 24; n++)
			send_request(make_layer(8'(n * 11 + 3), bit'($urandom_range(0, 1)), 1,
				bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1))));
		wait_drain();
	endtask

	// interleaved columns over several points, plus row reloads and noise
	task automatic test_random_columns();
		sample_t          s;
		int               sent;
		int               n_pts;
		int               depth;
		logic [IDX_W-1:0] pt0;
		bit               clr[8];
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			feed_pace = $urandom_range(0, 3) != 0;
			sink_pace = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 9))
				0: begin
					s = make_layer(IDX_W'($urandom), bit'($urandom_range(0, 1)),
						bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
						bit'($urandom_range(0, 1)));
					s.kind = 1'($urandom_range(0, 1));
					send_request(s);
					sent++;
				end
				1: begin
					send_request(make_row(IDX_W'($urandom_range(0, 2)), rand_coef(),
						rand_coef(), rand_coef()));
					sent++;
				end
				default: begin
					n_pts = $urandom_range(1, 4);
					depth = $urandom_range(1, 6);
					pt0   = IDX_W'($urandom);
					for (int k = 0; k < depth; k++)
						clr[k] = bit'($urandom_range(0, 1));
					for (int k = 0; k < depth; k++)
						for (int p = 0; p < n_pts; p++) begin
							s = make_layer(8'(pt0 + p * 37), k == 0, k == depth - 1, clr[k],
								(k < depth - 1) ? clr[k + 1] : bit'($urandom_range(0, 1)));
							// break the sequence now and then
							if ($urandom_range(0, 9) == 0)
								case ($urandom_range(0, 3))
									0: s.first_layer = ~s.first_layer;
									1: s.last_layer  = ~s.last_layer;
									2: s.layer_clear = ~s.layer_clear;
									default: s.next_clear = ~s.next_clear;
								endcase
							send_request(s);
							sent++;
						end
				end
			endcase
		end
		wait_drain();
	endtask

	initial begin
		for (int k = 0; k < NUM_REGIONS; k++)
			for (int p = 0; p < PTS; p++)
				top_rad[k][p] = '0;
		mismatches   = 0;
		hold_req     = 0;
		res_taken    = 1'b0;
		feed_pace    = 1'b1;
		sink_pace    = 1'b1;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_overlap_rows();
		test_clear_column();
		test_cloudy_column();
		test_field_extremes();
		test_result_backpressure();
		test_random_columns();

		if (surface_q.size() != 0) begin
			$display("%0d expected results never arrived", surface_q.size());
			mismatches += surface_q.size();
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// stop a hung run
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
